// ===== hdl/ipv4_route_lookup_forward_defines.svh =====
// assertion macros for the route lookup and forwarding block
`ifndef IPV4_ROUTE_LOOKUP_FORWARD_DEFINES_SVH
`define IPV4_ROUTE_LOOKUP_FORWARD_DEFINES_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define IRLF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define IRLF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRLF_ASSERT(lbl, prop, msg)
`define IRLF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/irlf_pkg.sv =====
// shared types, codes and helpers for the route lookup and forwarding block
package irlf_pkg;

	// default route table depth
	localparam int TABLE_DEPTH_DEF = 64;

	// number of 16-bit words summed into the header checksum
	localparam int CSUM_WORDS = 9;

	// operation codes
	localparam logic OP_FORWARD = 1'b0;
	localparam logic OP_ADD     = 1'b1;

	// result action codes
	localparam logic [2:0] ACT_LOCAL   = 3'd0;
	localparam logic [2:0] ACT_SEND    = 3'd1;
	localparam logic [2:0] ACT_NOROUTE = 3'd2;
	localparam logic [2:0] ACT_TTLERR  = 3'd3;
	localparam logic [2:0] ACT_ADDED   = 3'd4;
	localparam logic [2:0] ACT_FULL    = 3'd5;

	// input beat
	typedef struct packed {
		logic        op;
		logic [63:0] hdr_bytes_0_7;
		logic [63:0] hdr_bytes_8_15;
		logic [31:0] hdr_bytes_16_19;
		logic [15:0] pkt_length;
		logic [31:0] route_dest;
		logic [5:0]  route_prefix_len;
		logic [31:0] route_next_hop;
	} irlf_req_t;

	// result beat
	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] next_hop;
		logic [7:0]  new_ttl;
		logic [15:0] new_checksum;
		logic [15:0] out_length;
	} irlf_rsp_t;

	// one route table entry
	typedef struct packed {
		logic [31:0] prefix;
		logic [5:0]  len;
		logic [31:0] next_hop;
	} irlf_entry_t;

	// network mask for a prefix length of 1..32
	function automatic logic [31:0] mask_of(input logic [5:0] len);
		logic [31:0] m;
		m = ~(32'hffffffff >> len);
		return m;
	endfunction

	// clamp a prefix length into 1..32
	function automatic logic [5:0] clamp_len(input logic [5:0] len);
		logic [5:0] r;
		if (len == 6'd0) begin
			r = 6'd1;
		end else if (len > 6'd32) begin
			r = 6'd32;
		end else begin
			r = len;
		end
		return r;
	endfunction

endpackage

// ===== hdl/irlf_ram.sv =====
// generic single write port, single read port ram with registered read
module irlf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/irlf_match.sv =====
// prefix compare unit shared by route insert and route lookup
module irlf_match import irlf_pkg::*; (
	input  logic        is_add,
	input  logic [31:0] key,
	input  logic [5:0]  len,
	input  logic [5:0]  best_len,
	input  irlf_entry_t entry,
	output logic        hit
);

	logic [31:0] emask;
	logic        dup;
	logic        longer;

	// duplicate test for insert, longest match test for lookup
	always_comb begin
		emask  = mask_of(entry.len);
		dup    = (entry.len == len) && (entry.prefix == key);
		longer = (entry.len > best_len) && ((key & emask) == entry.prefix);
		hit    = is_add ? dup : longer;
	end

endmodule

// ===== hdl/irlf_csum.sv =====
// header checksum accumulator, one 16-bit word per cycle while add is high
module irlf_csum import irlf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clr,
	input  logic        add,
	input  logic [15:0] word,
	output logic [15:0] csum
);

	logic [19:0] acc_q;
	logic [16:0] fold1;
	logic [15:0] fold2;

	// running sum, wide enough for all words without loss
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (add) begin
			acc_q <= acc_q + {4'd0, word};
		end
	end

	// end-around carry fold and complement
	always_comb begin
		fold1 = {1'b0, acc_q[15:0]} + {13'd0, acc_q[19:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
		csum  = ~fold2;
	end

endmodule

// ===== hdl/ipv4_route_lookup_forward.sv =====
// ipv4 longest prefix match forwarding block, top level
//
// Usage: one command channel in, one result channel out, one config register.
// A beat is taken on a clock edge with start high and busy low; busy stays
// high until the result has been produced. op 1 adds a route, op 0 forwards
// a 20-byte header. Exactly one result beat follows each command: done is
// high for one cycle with rsp valid, and the receiver must take it then. The
// user writes local_address through cfg_we/cfg_wdata while idle; not enforced.
//
// Sequence: routes fill the table in order, so a fill count marks the valid
// entries. Each command scans the filled entries through the table ram, one
// read per cycle, and compares each entry once its registered read returns.
// An insert or a discard then gives done from the decide state; a sent
// header first sums the nine checksum words in the checksum state and gives
// done from the send state. The scan through the single ram read port sets
// the rate; done and the next start may share a cycle.
// Reset empties the table at once by clearing the fill count (no clearing
// pass) and sets local_address to zero.
`include "ipv4_route_lookup_forward_defines.svh"
module ipv4_route_lookup_forward import irlf_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  irlf_req_t   req,
	output logic        done,
	output irlf_rsp_t   rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = $bits(irlf_entry_t);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_CSUM   = 3'd3;
	localparam logic [2:0] S_SEND   = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic          rd_pend_q;
	irlf_req_t     item_q;
	logic [5:0]    rlen_q;
	logic [31:0]   rpre_q;
	logic          dup_q;
	logic [5:0]    best_len_q;
	logic [31:0]   best_nh_q;
	logic [3:0]    step_q;
	logic [31:0]   local_q;
	logic          done_q;
	irlf_rsp_t     rsp_q;

	logic          accept;
	logic          rd_en;
	logic          wr_en;
	logic          full;
	logic [EW-1:0] ram_rdata;
	irlf_entry_t   rd_entry;
	irlf_entry_t   wr_entry;
	logic          hit;
	logic [31:0]   key;
	logic [7:0]    ttl;
	logic [7:0]    ttl_dec;
	logic [15:0]   csum_word;
	logic [15:0]   csum;
	logic          csum_add;
	logic [31:0]   dst;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign rsp      = rsp_q;
	assign dst      = item_q.hdr_bytes_16_19;
	assign ttl      = item_q.hdr_bytes_8_15[63:56];
	assign ttl_dec  = ttl - 8'd1;
	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign rd_en    = (state_q == S_SCAN) && (idx_q < count_q);
	assign wr_en    = (state_q == S_DECIDE) && (item_q.op == OP_ADD) && !dup_q && !full;
	assign rd_entry = irlf_entry_t'(ram_rdata);
	assign key      = (item_q.op == OP_ADD) ? rpre_q : dst;
	assign csum_add = (state_q == S_CSUM);

	// new entry for an insert
	always_comb begin
		wr_entry.prefix   = rpre_q;
		wr_entry.len      = rlen_q;
		wr_entry.next_hop = item_q.route_next_hop;
	end

	// route table storage
	irlf_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// shared prefix compare
	irlf_match u_match (
		.is_add   (item_q.op == OP_ADD),
		.key      (key),
		.len      (rlen_q),
		.best_len (best_len_q),
		.entry    (rd_entry),
		.hit      (hit)
	);

	// checksum word select, the checksum field itself counts as zero
	always_comb begin
		unique case (step_q)
			4'd0:    csum_word = item_q.hdr_bytes_0_7[63:48];
			4'd1:    csum_word = item_q.hdr_bytes_0_7[47:32];
			4'd2:    csum_word = item_q.hdr_bytes_0_7[31:16];
			4'd3:    csum_word = item_q.hdr_bytes_0_7[15:0];
			4'd4:    csum_word = {ttl_dec, item_q.hdr_bytes_8_15[55:48]};
			4'd5:    csum_word = item_q.hdr_bytes_8_15[31:16];
			4'd6:    csum_word = item_q.hdr_bytes_8_15[15:0];
			4'd7:    csum_word = dst[31:16];
			default: csum_word = dst[15:0];
		endcase
	end

	// checksum adder
	irlf_csum u_csum (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (accept),
		.add    (csum_add),
		.word   (csum_word),
		.csum   (csum)
	);

	// local address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q <= '0;
		end else if (cfg_we) begin
			local_q <= cfg_wdata;
		end
	end

	// command payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
			rlen_q <= clamp_len(req.route_prefix_len);
			rpre_q <= req.route_dest & mask_of(clamp_len(req.route_prefix_len));
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			count_q    <= '0;
			rd_pend_q  <= 1'b0;
			dup_q      <= 1'b0;
			best_len_q <= '0;
			best_nh_q  <= '0;
			step_q     <= '0;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= S_SCAN;
						idx_q      <= '0;
						rd_pend_q  <= 1'b0;
						dup_q      <= 1'b0;
						best_len_q <= '0;
						step_q     <= '0;
					end
				end
				// one table read per cycle, each entry compared in the cycle after its read
				S_SCAN: begin
					idx_q     <= idx_q + CW'(rd_en);
					rd_pend_q <= rd_en;
					if (rd_pend_q && hit) begin
						if (item_q.op == OP_ADD) begin
							dup_q <= 1'b1;
						end else begin
							best_len_q <= rd_entry.len;
							best_nh_q  <= rd_entry.next_hop;
						end
					end
					if (!rd_en && !rd_pend_q) begin
						state_q <= S_DECIDE;
					end
				end
				// insert, or pick the forwarding outcome
				S_DECIDE: begin
					rsp_q.next_hop     <= '0;
					rsp_q.new_ttl      <= '0;
					rsp_q.new_checksum <= '0;
					rsp_q.out_length   <= item_q.pkt_length;
					if (item_q.op == OP_ADD) begin
						rsp_q.action <= (dup_q || !full) ? ACT_ADDED : ACT_FULL;
						if (wr_en) begin
							count_q <= count_q + CW'(1);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (dst == local_q) begin
						rsp_q.action <= ACT_LOCAL;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else if (best_len_q == 6'd0) begin
						rsp_q.action <= ACT_NOROUTE;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else if (ttl <= 8'd1) begin
						rsp_q.action <= ACT_TTLERR;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_CSUM;
					end
				end
				// sum header words
				S_CSUM: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'(CSUM_WORDS - 1)) begin
						state_q <= S_SEND;
					end
				end
				// forward result, direct delivery on the local subnet
				S_SEND: begin
					rsp_q.action       <= ACT_SEND;
					rsp_q.new_ttl      <= ttl_dec;
					rsp_q.new_checksum <= csum;
					rsp_q.out_length   <= item_q.pkt_length;
					if (((dst ^ local_q) & mask_of(best_len_q)) == 32'd0) begin
						rsp_q.next_hop <= dst;
					end else begin
						rsp_q.next_hop <= best_nh_q;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`IRLF_ASSERT(a_count_bound, count_q <= CW'(TABLE_DEPTH), "fill count beyond table depth")
	`IRLF_ASSERT(a_start_busy, accept |=> busy, "accepted beat did not raise busy")
	`IRLF_ASSERT(a_full_only_when_full, (done && rsp.action == ACT_FULL) |-> full, "full reported with room left")
	`IRLF_ASSERT(a_send_ttl, (done && rsp.action == ACT_SEND) |-> (rsp.new_ttl != 8'd0), "sent beat with zero ttl")
	`IRLF_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!done && !busy), "activity during reset")

endmodule

// ===== bench/ipv4_route_lookup_forward_tb.sv =====
// self-checking testbench for the ipv4 route lookup and forwarding block
module ipv4_route_lookup_forward_tb;
	import irlf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = TABLE_DEPTH_DEF;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 150;
	localparam int PHASES       = 6;
	localparam int POOL_SIZE    = 12;
	localparam int MAX_PRINTED  = 100;

	typedef struct {
		irlf_req_t item;
		bit        typed;
		irlf_rsp_t want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        start     = 1'b0;
	logic        busy;
	irlf_req_t   req       = '0;
	logic        done;
	irlf_rsp_t   rsp;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// predictor copy of the route table and the router address
	logic        route_valid [DEPTH];
	logic [31:0] route_prefix [DEPTH];
	logic [5:0]  route_len [DEPTH];
	logic [31:0] route_hop [DEPTH];
	logic [31:0] router_addr;

	irlf_rsp_t   awaited_rsp [$];
	plan_row_t   plan [$];
	logic [31:0] addr_pool [POOL_SIZE];
	int          mismatches = 0;
	int          quiet_cycles = 0;

	ipv4_route_lookup_forward #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// top bits set for a prefix length of 0..32
	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		logic [63:0] w;
		w = 64'hffffffff_00000000 >> len;
		return w[31:0];
	endfunction

	// expected result of one beat, updates the route table on an add
	function automatic irlf_rsp_t route_and_forward(input irlf_req_t r);
		irlf_rsp_t   o;
		logic [5:0]  len;
		logic [5:0]  best_len;
		logic [31:0] m;
		logic [31:0] pre;
		logic [31:0] dst;
		logic [31:0] sum;
		logic [7:0]  ttl;
		int          slot;
		int          best;
		logic        dup;
		o = '0;
		o.out_length = r.pkt_length;
		dst = r.hdr_bytes_16_19;
		if (r.op == OP_ADD) begin
			// out-of-range lengths snap to 1 or 32
			len = r.route_prefix_len;
			if (len == 6'd0) begin
				len = 6'd1;
			end else if (len > 6'd32) begin
				len = 6'd32;
			end
			m = prefix_mask(len);
			pre = r.route_dest & m;
			slot = -1;
			dup = 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				if (route_valid[i]) begin
					if (route_len[i] == len && route_prefix[i] == pre) dup = 1'b1;
				end else if (slot < 0) begin
					slot = i;
				end
			end
			if (dup) begin
				o.action = ACT_ADDED;
			end else if (slot < 0) begin
				o.action = ACT_FULL;
			end else begin
				route_valid[slot] = 1'b1;
				route_prefix[slot] = pre;
				route_len[slot] = len;
				route_hop[slot] = r.route_next_hop;
				o.action = ACT_ADDED;
			end
		end else if (dst == router_addr) begin
			o.action = ACT_LOCAL;
		end else begin
			// longest prefix wins, first entry on a tie
			best = -1;
			best_len = 6'd0;
			for (int i = 0; i < DEPTH; i++) begin
				if (route_valid[i] && route_len[i] > best_len
						&& (dst & prefix_mask(route_len[i])) == route_prefix[i]) begin
					best = i;
					best_len = route_len[i];
				end
			end
			ttl = r.hdr_bytes_8_15[63:56];
			if (best < 0) begin
				o.action = ACT_NOROUTE;
			end else if (ttl <= 8'd1) begin
				o.action = ACT_TTLERR;
			end else begin
				// header checksum with the checksum word taken as zero
				o.new_ttl = ttl - 8'd1;
				sum = r.hdr_bytes_0_7[63:48] + r.hdr_bytes_0_7[47:32]
					+ r.hdr_bytes_0_7[31:16] + r.hdr_bytes_0_7[15:0]
					+ {o.new_ttl, r.hdr_bytes_8_15[55:48]}
					+ r.hdr_bytes_8_15[31:16] + r.hdr_bytes_8_15[15:0]
					+ dst[31:16] + dst[15:0];
				repeat (2) sum = (sum & 32'h0000ffff) + (sum >> 16);
				o.new_checksum = ~sum[15:0];
				// direct delivery when on the router's own subnet
				if (((dst ^ router_addr) & prefix_mask(best_len)) == 32'd0) begin
					o.next_hop = dst;
				end else begin
					o.next_hop = route_hop[best];
				end
				o.action = ACT_SEND;
			end
		end
		return o;
	endfunction

	// forward beat with a plain header
	function automatic irlf_req_t fwd_hdr(input logic [31:0] dst, input logic [7:0] ttl,
			input logic [15:0] len);
		irlf_req_t r;
		r = '0;
		r.op = OP_FORWARD;
		r.hdr_bytes_0_7 = {8'h45, 8'h00, len, 16'h1c46, 16'h4000};
		r.hdr_bytes_8_15 = {ttl, 8'h06, 16'hb1e6, 32'hac100a63};
		r.hdr_bytes_16_19 = dst;
		r.pkt_length = len;
		return r;
	endfunction

	// add-route beat
	function automatic irlf_req_t route_add(input logic [31:0] dest, input logic [5:0] len,
			input logic [31:0] hop);
		irlf_req_t r;
		r = '0;
		r.op = OP_ADD;
		r.route_dest = dest;
		r.route_prefix_len = len;
		r.route_next_hop = hop;
		r.pkt_length = 16'h0040;
		return r;
	endfunction

	// result with only action and length set
	function automatic irlf_rsp_t verdict(input logic [2:0] act, input irlf_req_t r);
		irlf_rsp_t o;
		o = '0;
		o.action = act;
		o.out_length = r.pkt_length;
		return o;
	endfunction

	function automatic void plan_row(input irlf_req_t r, input bit typed, input logic [2:0] act);
		plan_row_t p;
		p.item = r;
		p.typed = typed;
		p.want = verdict(act, r);
		plan.push_back(p);
	endfunction

	// random beat aimed at the address pool
	function automatic irlf_req_t random_item();
		irlf_req_t   r;
		logic [5:0]  len;
		logic [31:0] base;
		int          pick;
		int          nbits;
		r.op = OP_FORWARD;
		r.hdr_bytes_0_7 = {$urandom, $urandom};
		r.hdr_bytes_8_15 = {$urandom, $urandom};
		r.hdr_bytes_16_19 = $urandom;
		r.pkt_length = 16'($urandom);
		r.route_dest = $urandom;
		r.route_prefix_len = 6'($urandom);
		r.route_next_hop = $urandom;
		base = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		if ($urandom_range(0, 99) < 15) begin
			// add a route near the pool
			r.op = OP_ADD;
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				len = 6'd0;
			end else if (pick < 6) begin
				len = 6'($urandom_range(33, 63));
			end else if (pick < 20) begin
				len = 6'd32;
			end else begin
				len = 6'($urandom_range(1, 31));
			end
			r.route_prefix_len = len;
			if ($urandom_range(0, 9) != 0) begin
				r.route_dest = (base & prefix_mask(len)) | ($urandom & ~prefix_mask(len));
			end
		end else begin
			// forward to the router, near the pool, or anywhere
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				r.hdr_bytes_16_19 = router_addr;
			end else if (pick < 80) begin
				nbits = $urandom_range(0, 24);
				r.hdr_bytes_16_19 = base ^ ($urandom & 32'((64'd1 << nbits) - 1));
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				r.hdr_bytes_8_15[63:56] = 8'd0;
			end else if (pick < 16) begin
				r.hdr_bytes_8_15[63:56] = 8'd1;
			end else if (pick < 20) begin
				r.hdr_bytes_8_15[63:56] = 8'd2;
			end
		end
		return r;
	endfunction

	// one line per mismatch, printing capped
	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("mismatch %0s: got %h want %h at %0t", what, got, want, $realtime);
		end
	endtask

	// present a beat and hold it until taken
	task automatic issue(input irlf_req_t r, input bit typed, input irlf_rsp_t want);
		irlf_rsp_t pred;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = route_and_forward(r);
		awaited_rsp.push_back(typed ? want : pred);
	endtask

	task automatic hold_off(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// register write once the block has drained
	task automatic set_router_addr(input logic [31:0] a);
		start <= 1'b0;
		@(posedge clk);
		while (awaited_rsp.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		router_addr = a;
		@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		irlf_rsp_t want;
		if (arst_n && done) begin
			if (awaited_rsp.size() == 0) begin
				flag_mismatch("unexpected result, action", 32'(rsp.action), 32'd0);
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.action !== want.action)
					flag_mismatch("action", 32'(rsp.action), 32'(want.action));
				if (rsp.next_hop !== want.next_hop)
					flag_mismatch("next_hop", rsp.next_hop, want.next_hop);
				if (rsp.new_ttl !== want.new_ttl)
					flag_mismatch("new_ttl", 32'(rsp.new_ttl), 32'(want.new_ttl));
				if (rsp.new_checksum !== want.new_checksum)
					flag_mismatch("new_checksum", 32'(rsp.new_checksum),
						32'(want.new_checksum));
				if (rsp.out_length !== want.out_length)
					flag_mismatch("out_length", 32'(rsp.out_length), 32'(want.out_length));
			end
		end
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		irlf_req_t r;
		bit        idle_on;
		// falling edge on reset so the flops clear before the first clock
		arst_n <= 1'b0;
		router_addr = '0;
		for (int i = 0; i < DEPTH; i++) begin
			route_valid[i] = 1'b0;
			route_prefix[i] = '0;
			route_len[i] = '0;
			route_hop[i] = '0;
		end
		for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

		// directed rows, router address still at reset value zero
		plan_row(fwd_hdr(32'h00000000, 8'd64, 16'h0054), 1, ACT_LOCAL);
		plan_row(fwd_hdr(32'h0a000001, 8'd64, 16'h0000), 1, ACT_NOROUTE);
		// no route beats a bad ttl
		plan_row(fwd_hdr(32'h0a000001, 8'd0, 16'hffff), 1, ACT_NOROUTE);
		plan_row(route_add(32'h0a000000, 6'd8, 32'hc0a80101), 1, ACT_ADDED);
		// same prefix once masked, dropped quietly
		plan_row(route_add(32'h0a010203, 6'd8, 32'h01020304), 1, ACT_ADDED);
		// zero length taken as one
		plan_row(route_add(32'h80000000, 6'd0, 32'h0b000001), 1, ACT_ADDED);
		// overlong length taken as 32, then repeated as a duplicate
		plan_row(route_add(32'h0a010203, 6'd63, 32'h0c000001), 1, ACT_ADDED);
		plan_row(route_add(32'h0a010203, 6'd32, 32'h0c0000ff), 1, ACT_ADDED);
		plan_row(fwd_hdr(32'h0a010203, 8'd1, 16'h0100), 1, ACT_TTLERR);
		plan_row(fwd_hdr(32'h0a0000ff, 8'd0, 16'h0100), 1, ACT_TTLERR);
		r = fwd_hdr(32'h0a010203, 8'd255, 16'hffff);
		r.hdr_bytes_0_7 = '1;
		r.hdr_bytes_8_15 = '1;
		r.route_dest = '1;
		r.route_prefix_len = '1;
		r.route_next_hop = '1;
		plan_row(r, 0, ACT_SEND);
		plan_row(fwd_hdr(32'h0a0000ff, 8'd2, 16'h003c), 0, ACT_SEND);
		plan_row(fwd_hdr(32'hffffffff, 8'd128, 16'h05dc), 0, ACT_SEND);
		plan_row(fwd_hdr(32'h7fffffff, 8'd5, 16'h0028), 1, ACT_NOROUTE);
		plan_row(route_add(32'h00000000, 6'd1, 32'h0d000001), 1, ACT_ADDED);
		// on the router's own subnet, sent straight to the destination
		plan_row(fwd_hdr(32'h7fffffff, 8'd2, 16'h0028), 0, ACT_SEND);
		plan_row(route_add(32'hffffffff, 6'd32, 32'hffffffff), 1, ACT_ADDED);
		plan_row(fwd_hdr(32'hffffffff, 8'd255, 16'h0500), 0, ACT_SEND);
		r = fwd_hdr(32'h00000001, 8'd0, 16'h0000);
		r.hdr_bytes_0_7 = '0;
		r.hdr_bytes_8_15 = '0;
		plan_row(r, 1, ACT_TTLERR);
		plan_row(route_add(32'h0a0a0000, 6'd16, 32'h0e000001), 1, ACT_ADDED);
		plan_row(fwd_hdr(32'h0a0a0505, 8'd64, 16'h0200), 0, ACT_SEND);

		// reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			issue(plan[i].item, plan[i].typed, plan[i].want);
			if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 12));
		end

		// random phases, each under its own router address
		idle_on = 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_router_addr(32'hffffffff);
				1: set_router_addr(addr_pool[0]);
				2: set_router_addr(32'h00000000);
				3: set_router_addr($urandom);
				4: set_router_addr(addr_pool[5] ^ ($urandom & 32'h000000ff));
				default: set_router_addr(addr_pool[2]);
			endcase
			if (ph == PHASES - 1) idle_on = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				issue(random_item(), 0, '0);
				if (ph != PHASES - 1 && $urandom_range(0, 39) == 0) idle_on = !idle_on;
				if (idle_on && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 12));
			end
		end

		// drain
		start <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
